@@ rtl/jls_pkg.sv @@
// Package for the Jacobi linear solver: request/result types, codes, constants.
// No dependencies.
package jls_pkg;

    localparam int DEF_MAX_N     = 16;
    localparam int DEF_FRAC_BITS = 16;

    typedef enum logic [1:0] {
        MODE_COEF  = 2'd0,
        MODE_RHS   = 2'd1,
        MODE_SOLVE = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0,
        ST_LIMIT     = 2'd1,
        ST_ZERO_DIAG = 2'd2,
        ST_UNUSED    = 2'd3
    } status_t;

    localparam logic [1:0] REG_SIZE = 2'd0;
    localparam logic [1:0] REG_TOL  = 2'd1;
    localparam logic [1:0] REG_MAXI = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } request_t;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] solution_value;
        logic [1:0]         status;
        logic               last;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIAG,
        S_DIAG_W,
        S_ROW_INIT,
        S_MAC,
        S_MAC_W,
        S_DIV,
        S_DIV_W,
        S_SWEEP_END,
        S_EMIT,
        S_EMIT_W
    } state_t;

    typedef struct packed {
        logic clear;
        logic rd_diag;
        logic row_init;
        logic mac_rd;
        logic mac_acc;
        logic div_start;
        logic div_store;
        logic sweep_end;
        logic emit_rd;
        logic emit_out;
    } cmd_t;

    typedef struct packed {
        logic diag_zero;
        logic div_done;
        logic converged;
    } stat_t;

endpackage

@@ rtl/jls_divider.sv @@
// Restoring signed divider, one quotient bit per cycle, truncation toward zero.
// Depends on jls_pkg.
module jls_divider
    import jls_pkg::*;
#(
    parameter int NW = 64,
    parameter int DW = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[NW-1]};
        diff      = {1'b0, trial} - {2'b00, d_reg};
        if (start)
        begin
            q_next   = num[NW-1] ? NW'(-num) : NW'(num);
            d_next   = den[DW-1] ? DW'(-den) : DW'(den);
            neg_next = num[NW-1] ^ den[DW-1];
            r_next   = '0;
            cnt_next = CW'(NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!diff[DW+1])
            begin
                r_next = diff[DW-1:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[DW-1:0];
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? NW'(-q_reg) : NW'(q_reg);
endmodule

@@ rtl/jls_datapath.sv @@
// Datapath: coefficient/rhs/solution memories, multiply-accumulate, divide, change test.
// Depends on jls_pkg and jls_divider.
module jls_datapath
    import jls_pkg::*;
#(
    parameter int MAX_N     = DEF_MAX_N,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load_we,
    input  request_t                 req,
    input  cmd_t                     cmd,
    input  logic [$clog2(MAX_N)-1:0] ri,
    input  logic [$clog2(MAX_N)-1:0] cj,
    input  logic [15:0]              tol,
    input  logic [1:0]               status_code,
    input  logic                     last_flag,
    output stat_t                    stat,
    output logic                     out_valid,
    output result_t                  out_data
);
    localparam int IW  = $clog2(MAX_N);
    localparam int AW  = 2 * IW;
    localparam int SW  = 64 + IW;
    localparam int NW  = 64;
    localparam logic signed [SW-1:0] LIM_HI = SW'((64'sd1 <<< (62 - FRAC_BITS)) - 1);
    localparam logic signed [SW-1:0] LIM_LO = SW'(-(64'sd1 <<< (62 - FRAC_BITS)));

    logic signed [31:0] coef_mem [2**AW];
    logic signed [31:0] rhs_mem  [MAX_N];
    logic signed [31:0] cur_mem  [MAX_N];
    logic signed [31:0] nxt_mem  [MAX_N];

    logic signed [31:0] a_rd_reg, x_rd_reg, b_rd_reg, o_rd_reg;
    logic signed [63:0] prod_reg;
    logic               prod_v_reg;
    logic               mac_v_reg;
    logic signed [SW-1:0] acc_reg;
    logic signed [31:0] diag_reg;
    logic               zero_reg;
    logic [31:0]        worst_reg;
    logic               out_v_reg;
    result_t            out_reg;
    logic               div_done;
    logic signed [NW-1:0] quo;
    logic signed [SW-1:0] numer;
    logic signed [NW-1:0] numer_sat;
    logic signed [31:0] qsat;
    logic signed [32:0] dlt;
    logic [31:0]        dabs;
    logic [AW-1:0]      a_addr;
    logic               load_coef, load_rhs;

    assign load_coef = load_we && (req.mode == MODE_COEF)
                       && (32'(req.row) < MAX_N) && (32'(req.col) < MAX_N);
    assign load_rhs  = load_we && (req.mode == MODE_RHS) && (32'(req.row) < MAX_N);

    always_comb
    begin
        a_addr = cmd.mac_rd ? {ri, cj} : {ri, ri};
    end

    always_ff @(posedge clk)
    begin
        if (load_coef)
        begin
            coef_mem[{IW'(req.row), IW'(req.col)}] <= req.value;
        end
        if (load_rhs)
        begin
            rhs_mem[IW'(req.row)] <= req.value;
        end
        a_rd_reg <= coef_mem[a_addr];
        x_rd_reg <= cur_mem[cj];
        b_rd_reg <= rhs_mem[ri];
        o_rd_reg <= cur_mem[ri];
    end

    always_comb
    begin
        numer = SW'(b_rd_reg) - acc_reg;
        if (numer > LIM_HI)
        begin
            numer_sat = NW'(LIM_HI);
        end
        else if (numer < LIM_LO)
        begin
            numer_sat = NW'(LIM_LO);
        end
        else
        begin
            numer_sat = NW'(numer);
        end
        if (quo > 64'sd2147483647)
        begin
            qsat = 32'sh7fffffff;
        end
        else if (quo < -64'sd2147483648)
        begin
            qsat = 32'sh80000000;
        end
        else
        begin
            qsat = quo[31:0];
        end
        dlt  = 33'(qsat) - 33'(o_rd_reg);
        dabs = dlt[32] ? 32'(-dlt) : dlt[31:0];
    end

    jls_divider #(.NW(NW), .DW(32)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (numer_sat <<< FRAC_BITS),
        .den   (diag_reg),
        .done  (div_done),
        .quo   (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
        begin
            nxt_mem[ri] <= qsat;
        end
        if (cmd.sweep_end || cmd.clear)
        begin
            for (int k = 0; k < MAX_N; k++)
            begin
                cur_mem[k] <= cmd.clear ? 32'sd0 : nxt_mem[k];
            end
        end
        prod_reg <= a_rd_reg * x_rd_reg;
        if (cmd.row_init)
        begin
            acc_reg <= '0;
        end
        else if (mac_v_reg)
        begin
            acc_reg <= acc_reg + SW'(prod_reg >>> FRAC_BITS);
        end
        if (cmd.mac_acc)
        begin
            diag_reg <= a_rd_reg;
        end
        out_reg.index          <= 4'(ri);
        out_reg.solution_value <= zero_reg ? 32'sd0 : o_rd_reg;
        out_reg.status         <= status_code;
        out_reg.last           <= last_flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
            mac_v_reg  <= 1'b0;
            zero_reg   <= 1'b0;
            worst_reg  <= '0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            prod_v_reg <= cmd.mac_rd;
            mac_v_reg  <= prod_v_reg;
            out_v_reg  <= cmd.emit_out;
            if (cmd.clear)
            begin
                zero_reg  <= 1'b0;
                worst_reg <= '0;
            end
            else
            begin
                if (cmd.rd_diag && a_rd_reg == 32'sd0)
                begin
                    zero_reg <= 1'b1;
                end
                if (cmd.div_store && dabs > worst_reg)
                begin
                    worst_reg <= dabs;
                end
                if (cmd.sweep_end)
                begin
                    worst_reg <= '0;
                end
            end
        end
    end

    assign stat.diag_zero = zero_reg;
    assign stat.div_done  = div_done;
    assign stat.converged = worst_reg < {16'd0, tol};
    assign out_valid      = out_v_reg;
    assign out_data       = out_reg;
endmodule

@@ rtl/jls_controller.sv @@
// Controller state machine sequencing diagonal check, sweeps and result emission.
// Depends on jls_pkg.
module jls_controller
    import jls_pkg::*;
#(
    parameter int MAX_N = DEF_MAX_N
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     go,
    input  logic [4:0]               size_cfg,
    input  logic [15:0]              maxi_cfg,
    input  stat_t                    stat,
    output cmd_t                     cmd,
    output logic                     busy,
    output logic [$clog2(MAX_N)-1:0] ri,
    output logic [$clog2(MAX_N)-1:0] cj,
    output logic [1:0]               status_code,
    output logic                     last_flag
);
    localparam int IW = $clog2(MAX_N);
    localparam int CW = IW + 1;

    state_t        state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, n_reg, n_next;
    logic [15:0]   sw_reg, sw_next, lim_reg, lim_next;
    logic [1:0]    st_reg, st_next;
    logic [CW-1:0] n_eff;

    always_comb
    begin
        if (size_cfg == 5'd0)
        begin
            n_eff = CW'(1);
        end
        else if (32'(size_cfg) > MAX_N)
        begin
            n_eff = CW'(MAX_N);
        end
        else
        begin
            n_eff = CW'(size_cfg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        sw_next    = sw_reg;
        lim_next   = lim_reg;
        st_next    = st_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    cmd.clear  = 1'b1;
                    n_next     = n_eff;
                    lim_next   = (maxi_cfg == 16'd0) ? 16'd1 : maxi_cfg;
                    sw_next    = '0;
                    i_next     = '0;
                    state_next = S_DIAG;
                end
            end
            S_DIAG:
            begin
                state_next = S_DIAG_W;
            end
            S_DIAG_W:
            begin
                cmd.rd_diag = 1'b1;
                if (i_reg == n_reg - 1'b1)
                begin
                    i_next     = '0;
                    state_next = S_ROW_INIT;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_DIAG;
                end
            end
            S_ROW_INIT:
            begin
                if (stat.diag_zero)
                begin
                    st_next    = ST_ZERO_DIAG;
                    i_next     = '0;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.row_init = 1'b1;
                    j_next       = '0;
                    state_next   = S_MAC;
                end
            end
            S_MAC:
            begin
                if (j_reg != i_reg)
                begin
                    cmd.mac_rd = 1'b1;
                end
                if (j_reg == n_reg - 1'b1)
                begin
                    state_next = S_MAC_W;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
            end
            S_MAC_W:
            begin
                j_next = j_reg + 1'b1;
                if (j_reg == n_reg + 1'b1)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.mac_acc = 1'b1;
                state_next  = S_DIV_W;
            end
            S_DIV_W:
            begin
                if (j_reg == '0)
                begin
                    cmd.div_start = 1'b1;
                    j_next        = CW'(1);
                end
                else if (stat.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (i_reg == n_reg - 1'b1)
                    begin
                        state_next = S_SWEEP_END;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_ROW_INIT;
                    end
                end
            end
            S_SWEEP_END:
            begin
                cmd.sweep_end = 1'b1;
                sw_next       = sw_reg + 1'b1;
                i_next        = '0;
                if (stat.converged)
                begin
                    st_next    = ST_CONVERGED;
                    state_next = S_EMIT;
                end
                else if (sw_reg + 1'b1 >= lim_reg)
                begin
                    st_next    = ST_LIMIT;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_ROW_INIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = S_EMIT_W;
            end
            S_EMIT_W:
            begin
                cmd.emit_out = 1'b1;
                if (i_reg == n_reg - 1'b1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_EMIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_DIV && 1'b1)
        begin
            j_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= CW'(1);
            sw_reg    <= '0;
            lim_reg   <= 16'd1;
            st_reg    <= ST_CONVERGED;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            sw_reg    <= sw_next;
            lim_reg   <= lim_next;
            st_reg    <= st_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign ri          = i_reg[IW-1:0];
    assign cj          = j_reg[IW-1:0];
    assign status_code = st_reg;
    assign last_flag   = (i_reg == n_reg - 1'b1);

    a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_W && last_flag) |=> (state_reg == S_IDLE))
        else $error("emission did not end after last component");
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (sw_reg <= lim_reg))
        else $error("sweep count passed limit");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (i_reg < n_reg))
        else $error("row index out of range");
endmodule

@@ rtl/jacobi_linear_solver.sv @@
// Top level of the Jacobi linear solver: config registers, controller, datapath.
// Depends on jls_pkg, jls_controller, jls_datapath.
//
// Load requests (coefficient or right-hand side) are taken only while not busy. A solve
// request holds busy through the diagonal check, then, unless a diagonal is zero,
// per sweep n rows of multiply-accumulate plus the bit-serial divider, then the
// close of the sweep, then the emission of one result per row.
// Results appear for one cycle with result_valid and cannot be stalled.
module jacobi_linear_solver
    import jls_pkg::*;
#(
    parameter int MAX_N     = DEF_MAX_N,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  request_t    request,
    output logic        result_valid,
    output result_t     result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    localparam int IW = $clog2(MAX_N);

    logic [4:0]  size_reg;
    logic [15:0] tol_reg, maxi_reg;
    logic        take, go;
    cmd_t        cmd;
    stat_t       stat;
    logic [IW-1:0] ri, cj;
    logic [1:0]  status_code;
    logic        last_flag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 5'd16;
            tol_reg  <= 16'd66;
            maxi_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SIZE: size_reg <= cfg_data[4:0];
                REG_TOL:  tol_reg  <= cfg_data;
                REG_MAXI: maxi_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign take = start && !busy;
    assign go   = take && (request.mode == MODE_SOLVE);

    jls_controller #(.MAX_N(MAX_N)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .size_cfg    (size_reg),
        .maxi_cfg    (maxi_reg),
        .stat        (stat),
        .cmd         (cmd),
        .busy        (busy),
        .ri          (ri),
        .cj          (cj),
        .status_code (status_code),
        .last_flag   (last_flag)
    );

    jls_datapath #(.MAX_N(MAX_N), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_we     (take),
        .req         (request),
        .cmd         (cmd),
        .ri          (ri),
        .cj          (cj),
        .tol         (tol_reg),
        .status_code (status_code),
        .last_flag   (last_flag),
        .stat        (stat),
        .out_valid   (result_valid),
        .out_data    (result)
    );
endmodule
